/* sv/ssrch_pkg.sv */
// ----------------------------------------------------------------------------
// ssrch_pkg
// Shared types, constants and byte helpers for the streaming substring search.
// ----------------------------------------------------------------------------
package ssrch_pkg;

   localparam int MaxNeedle = 16;
   localparam int IdxWidth  = $clog2(MaxNeedle);
   localparam int LenWidth  = $clog2(MaxNeedle + 1);
   localparam int PosWidth  = 32;
   localparam int CsrWidth  = 64;

   localparam logic [7:0] CaseBit = 8'd32;
   localparam logic [PosWidth-1:0] PosMax = '1;

   typedef logic [7:0] byte_type;
   typedef byte_type [MaxNeedle-1:0] window_type;
   typedef logic [LenWidth-1:0] len_type;
   typedef logic [PosWidth-1:0] pos_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_NEEDLE_LOW    = 2'd0,
      REG_NEEDLE_HIGH   = 2'd1,
      REG_NEEDLE_LENGTH = 2'd2,
      REG_CASE_FOLD     = 2'd3
   } csr_index_type;

   // compare outcome for one haystack byte
   typedef struct packed {
      logic    hit;
      pos_type offset;
   } match_type;

   // ascii lower-casing, only A to Z fold
   function automatic byte_type fold_byte(input byte_type b);
      byte_type r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) begin
         r = b | CaseBit;
      end
      return r;
   endfunction

endpackage

/* sv/ssrch_req_if.sv */
// ----------------------------------------------------------------------------
// ssrch_req_if
// Haystack byte channel: valid/ready handshake with one byte per transaction.
// ----------------------------------------------------------------------------
interface ssrch_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_haystack;

   modport source (output valid, output data_byte, output end_of_haystack, input ready);
   modport sink   (input valid, input data_byte, input end_of_haystack, output ready);
endinterface

/* sv/ssrch_rsp_if.sv */
// ----------------------------------------------------------------------------
// ssrch_rsp_if
// Search result channel: valid/ready handshake carrying found and offset.
// ----------------------------------------------------------------------------
interface ssrch_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] match_offset;

   modport source (output valid, output found, output match_offset, input ready);
   modport sink   (input valid, input found, input match_offset, output ready);
endinterface

/* sv/ssrch_match.sv */
// ----------------------------------------------------------------------------
// ssrch_match
// Parallel compare of the shifted window against the needle, with offset.
// ----------------------------------------------------------------------------
module ssrch_match
   import ssrch_pkg::*;
(
   input  window_type win,
   input  window_type needle,
   input  len_type    len,
   input  logic       case_fold,
   input  pos_type    position,
   output match_type  result
);

   logic [MaxNeedle-1:0] eq;

   // needle byte k lines up with window entry len-1-k
   always_comb begin
      for (int k = 0; k < MaxNeedle; k++) begin
         len_type  j;
         byte_type h;
         byte_type n;
         j = len - LenWidth'(1) - LenWidth'(k);
         h = win[j[IdxWidth-1:0]];
         n = needle[k];
         if (case_fold) begin
            h = fold_byte(h);
            n = fold_byte(n);
         end
         eq[k] = (LenWidth'(k) >= len) || (h == n);
      end
   end

   // empty needle matches at once in exact mode, never in case-fold mode
   always_comb begin
      if (len == '0) begin
         result.hit    = !case_fold;
         result.offset = '0;
      end else begin
         result.hit    = (position >= PosWidth'(len)) && (&eq);
         result.offset = position - PosWidth'(len);
      end
   end

endmodule

/* sv/streaming_substring_search_top.sv */
// ----------------------------------------------------------------------------
// streaming_substring_search_top
// First-occurrence needle search over a byte stream, one result per haystack.
// ----------------------------------------------------------------------------
// a result passes from the input register through the compare into the result register on rsp_chan
// throughput: one byte per cycle while no result waits on rsp_chan, set by the single compare stage
// a result waiting on rsp_chan holds the compare stage, so intake stalls
// once the input register also holds a byte
// reset is synchronous and active high: needle, window, position cleared
// ----------------------------------------------------------------------------
module streaming_substring_search_top
   import ssrch_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   ssrch_req_if.sink           req_chan,
   ssrch_rsp_if.source         rsp_chan,
   input  logic                csr_write_en,
   input  logic [1:0]          csr_index,
   input  logic [CsrWidth-1:0] csr_data
);

   // configuration registers
   logic [CsrWidth-1:0] needle_low_ff;
   logic [CsrWidth-1:0] needle_high_ff;
   len_type             needle_length_ff;
   logic                case_fold_ff;

   // input register
   logic     in_valid_ff;
   byte_type in_byte_ff;
   logic     in_last_ff;

   // search state
   window_type window_ff, window_in;
   pos_type    position_ff, position_in;
   logic       reported_ff, reported_in;

   // result register
   logic    out_valid_ff, out_valid_in;
   logic    out_found_ff, out_found_in;
   pos_type out_offset_ff, out_offset_in;

   window_type needle;
   window_type win_shift;
   pos_type    pos_next;
   len_type    len_sat;
   match_type  match;
   logic       advance;
   logic       emit;

   // the input stage moves on whenever the result slot is free or draining
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.found        = out_found_ff;
   assign rsp_chan.match_offset = out_offset_ff;

   // needle bytes from the two 64-bit registers
   always_comb begin
      for (int k = 0; k < MaxNeedle / 2; k++) begin
         needle[k]                 = needle_low_ff[8*k +: 8];
         needle[k + MaxNeedle / 2] = needle_high_ff[8*k +: 8];
      end
   end

   assign len_sat = (needle_length_ff > LenWidth'(MaxNeedle)) ?
                    LenWidth'(MaxNeedle) : needle_length_ff;

   // window shifted by the new byte and saturating position
   always_comb begin
      win_shift[0] = in_byte_ff;
      for (int i = 1; i < MaxNeedle; i++) begin
         win_shift[i] = window_ff[i-1];
      end
      pos_next = (position_ff == PosMax) ? PosMax : position_ff + PosWidth'(1);
   end

   ssrch_match u_match (
      .win       (win_shift),
      .needle    (needle),
      .len       (len_sat),
      .case_fold (case_fold_ff),
      .position  (pos_next),
      .result    (match)
   );

   assign emit = !reported_ff && (match.hit || in_last_ff);

   // next state and result
   always_comb begin
      window_in     = window_ff;
      position_in   = position_ff;
      reported_in   = reported_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_found_in  = out_found_ff;
      out_offset_in = out_offset_ff;
      if (in_valid_ff && advance) begin
         if (emit) begin
            out_valid_in  = 1'b1;
            out_found_in  = match.hit;
            out_offset_in = match.hit ? match.offset : '0;
         end
         if (in_last_ff) begin
            window_in   = '0;
            position_in = '0;
            reported_in = 1'b0;
         end else begin
            window_in   = win_shift;
            position_in = pos_next;
            reported_in = reported_ff || match.hit;
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         needle_low_ff    <= '0;
         needle_high_ff   <= '0;
         needle_length_ff <= '0;
         case_fold_ff     <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            REG_NEEDLE_LOW:    needle_low_ff    <= csr_data;
            REG_NEEDLE_HIGH:   needle_high_ff   <= csr_data;
            REG_NEEDLE_LENGTH: needle_length_ff <= csr_data[LenWidth-1:0];
            REG_CASE_FOLD:     case_fold_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.end_of_haystack;
      end
   end

   // search state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         position_ff  <= '0;
         reported_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         position_ff  <= position_in;
         reported_ff  <= reported_in;
         out_valid_ff <= out_valid_in;
      end
      out_found_ff  <= out_found_in;
      out_offset_ff <= out_offset_in;
   end

endmodule

/* dv/ssrch_result_checker.sv */
// ----------------------------------------------------------------------------
// ssrch_result_checker
// Watches the haystack, result and register ports of the substring search,
// keeps its own copy of the search state, and compares every result
// transaction with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ssrch_result_checker
   import ssrch_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   ssrch_req_if                req_mon,
   ssrch_rsp_if                rsp_mon,
   input  logic                csr_write_en,
   input  logic [1:0]          csr_index,
   input  logic [CsrWidth-1:0] csr_data,
   output int unsigned         error_count,
   output int unsigned         results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int       ReportLimit = 10;
   localparam byte_type UpperA      = 8'h41;
   localparam byte_type UpperZ      = 8'h5A;
   localparam byte_type LowerBit    = 8'h20;

   // shadow of the needle registers, {high, low}
   logic [2*CsrWidth-1:0] needle_bits;
   logic [4:0]            needle_len_reg;
   logic                  fold_en;

   // shadow of the search state, entry 0 holds the newest byte
   window_type recent_bytes;
   pos_type    bytes_seen;
   logic       result_given;

   match_type search_results_due[$];

   function automatic byte_type to_lower(input byte_type b);
      if (b >= UpperA && b <= UpperZ) begin
         return b | LowerBit;
      end
      return b;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      error_count++;
      if (error_count <= ReportLimit) begin
         $display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
      end
   endtask

   // advance the search by one haystack byte and queue any result it causes
   task automatic scan_byte(input byte_type b, input logic last);
      int unsigned len;
      int unsigned k;
      logic        hit;
      pos_type     off;
      byte_type    h;
      byte_type    nb;
      match_type   due;
      len = (needle_len_reg > MaxNeedle) ? MaxNeedle : needle_len_reg;
      recent_bytes = {recent_bytes[MaxNeedle-2:0], b};
      if (bytes_seen != PosMax) begin
         bytes_seen++;
      end
      if (!result_given) begin
         hit = 1'b0;
         off = '0;
         if (len == 0) begin
            hit = !fold_en;
         end else if (bytes_seen >= len) begin
            hit = 1'b1;
            for (k = 0; k < len; k++) begin
               h  = recent_bytes[len-1-k];
               nb = needle_bits[8*k +: 8];
               if (fold_en) begin
                  h  = to_lower(h);
                  nb = to_lower(nb);
               end
               if (h != nb) begin
                  hit = 1'b0;
               end
            end
            off = bytes_seen - len;
         end
         if (hit) begin
            due.hit    = 1'b1;
            due.offset = off;
            search_results_due.push_back(due);
            result_given = 1'b1;
         end else if (last) begin
            due.hit    = 1'b0;
            due.offset = '0;
            search_results_due.push_back(due);
         end
      end
      // end of haystack starts a fresh search
      if (last) begin
         recent_bytes = '0;
         bytes_seen   = '0;
         result_given = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      match_type due;
      if (reset) begin
         needle_bits    = '0;
         needle_len_reg = '0;
         fold_en        = 1'b0;
         recent_bytes   = '0;
         bytes_seen     = '0;
         result_given   = 1'b0;
         search_results_due.delete();
         error_count    = 0;
      end else begin
         // register writes
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               REG_NEEDLE_LOW:    needle_bits[CsrWidth-1:0] = csr_data;
               REG_NEEDLE_HIGH:   needle_bits[2*CsrWidth-1:CsrWidth] = csr_data;
               REG_NEEDLE_LENGTH: needle_len_reg = csr_data[4:0];
               REG_CASE_FOLD:     fold_en = csr_data[0];
               default: ;
            endcase
         end
         // haystack transaction
         if (req_mon.valid && req_mon.ready) begin
            scan_byte(req_mon.data_byte, req_mon.end_of_haystack);
         end
         // result transaction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (search_results_due.size() == 0) begin
               report_mismatch("result with nothing outstanding", '0,
                               rsp_mon.match_offset);
            end else begin
               due = search_results_due.pop_front();
               if (rsp_mon.found !== due.hit) begin
                  report_mismatch("found", 32'(due.hit), 32'(rsp_mon.found));
               end
               if (rsp_mon.match_offset !== due.offset) begin
                  report_mismatch("match_offset", due.offset, rsp_mon.match_offset);
               end
            end
         end
      end
      results_due = search_results_due.size();
   end

endmodule

/* dv/streaming_substring_search_top_tb.sv */
// ----------------------------------------------------------------------------
// streaming_substring_search_top_tb
// Drives haystack bytes and needle settings into the substring search: a
// short directed part for the corner cases, a long result back-pressure
// stretch, then random needles and haystacks that mostly carry the needle.
// Checking is done by the result checker beside the block.
// ----------------------------------------------------------------------------
module streaming_substring_search_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ssrch_pkg::*;

   localparam int       ItemTarget    = 1750;
   localparam int       QuietItems    = 250;
   localparam int       HoldOffCycles = 300;
   localparam int       SettleCycles  = 8;
   localparam int       MaxHaystack   = 64;
   localparam byte_type LowerBit      = 8'h20;
   localparam byte_type LowerA        = 8'h61;
   localparam byte_type LowerZ        = 8'h7A;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_en;
   logic [1:0]          csr_index;
   logic [CsrWidth-1:0] csr_data;
   int unsigned         error_count;
   int unsigned         results_due;

   ssrch_req_if req_bus ();
   ssrch_rsp_if rsp_bus ();

   // stimulus control
   int  items_sent  = 0;
   bit  quiet       = 1'b0;
   bit  req_gaps_on = 1'b0;
   bit  rsp_gaps_on = 1'b1;
   bit  hold_off    = 1'b0;
   bit  pressure_go = 1'b0;

   // needle as last programmed, for planting it in haystacks
   byte_type cur_needle [MaxNeedle];
   int       cur_len;
   logic     cur_fold;

   streaming_substring_search_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_bus),
      .rsp_chan     (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   ssrch_result_checker result_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .error_count  (error_count),
      .results_due  (results_due)
   );

   always #5 clock = ~clock;

   // run limit
   initial begin
      #3_000_000;
      $display("streaming_substring_search_top_tb: done, errors");
      $finish;
   end

   // result ready with random stall bursts
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
         end else if (rsp_gaps_on && !quiet && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // long receiver hold-off so results back up into the input
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HoldOffCycles) @(posedge clock);
      hold_off = 1'b0;
   end

   // mostly bytes that appear in needles, else anything
   function automatic byte_type random_byte(input bit narrow);
      if (!narrow) begin
         return byte_type'($urandom_range(0, 255));
      end
      case ($urandom_range(0, 7))
         0: return 8'h61;  // a
         1: return 8'h41;  // A
         2: return 8'h62;  // b
         3: return 8'h42;  // B
         4: return 8'h40;  // just below A
         5: return 8'h5B;  // just above Z
         6: return 8'h60;  // @ with the case bit set
         default: return 8'h00;
      endcase
   endfunction

   task automatic send_byte(input byte_type b, input logic last);
      @(negedge clock);
      req_bus.valid           <= 1'b1;
      req_bus.data_byte       <= b;
      req_bus.end_of_haystack <= last;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      if (req_gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CsrWidth-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
   endtask

   task automatic program_needle(input logic [CsrWidth-1:0] lo, input logic [CsrWidth-1:0] hi,
                                 input int len, input logic fold);
      int i;
      write_reg(REG_NEEDLE_LOW, lo);
      write_reg(REG_NEEDLE_HIGH, hi);
      write_reg(REG_NEEDLE_LENGTH, CsrWidth'(len));
      write_reg(REG_CASE_FOLD, CsrWidth'(fold));
      @(negedge clock);
      csr_write_en <= 1'b0;
      for (i = 0; i < 8; i++) begin
         cur_needle[i]   = lo[8*i +: 8];
         cur_needle[i+8] = hi[8*i +: 8];
      end
      cur_len  = (len > MaxNeedle) ? MaxNeedle : len;
      cur_fold = fold;
   endtask

   // stop offering, wait for every outstanding result, let the pipe drain
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic random_config();
      logic [CsrWidth-1:0] lo;
      logic [CsrWidth-1:0] hi;
      int                  len;
      int                  i;
      for (i = 0; i < 8; i++) begin
         lo[8*i +: 8] = random_byte(1'b1);
         hi[8*i +: 8] = random_byte(1'b1);
      end
      if ($urandom_range(0, 3) == 0) begin
         lo = {$urandom, $urandom};
      end
      if ($urandom_range(0, 3) == 0) begin
         hi = {$urandom, $urandom};
      end
      case ($urandom_range(0, 9))
         0: len = 0;
         1: len = MaxNeedle;
         2: len = $urandom_range(MaxNeedle + 1, 31);
         3: len = $urandom_range(6, MaxNeedle - 1);
         default: len = $urandom_range(1, 5);
      endcase
      program_needle(lo, hi, len, 1'($urandom_range(0, 1)));
   endtask

   // one haystack, usually with the needle planted somewhere in it
   task automatic send_haystack();
      byte_type hay [MaxHaystack];
      int       hay_len;
      int       spot;
      int       i;
      byte_type lowered;
      hay_len = cur_len + $urandom_range(0, 20);
      if (hay_len == 0) begin
         hay_len = 1;
      end
      for (i = 0; i < hay_len; i++) begin
         hay[i] = random_byte($urandom_range(0, 4) != 0);
      end
      if (cur_len > 0 && $urandom_range(0, 9) < 7) begin
         spot = $urandom_range(0, hay_len - cur_len);
         for (i = 0; i < cur_len; i++) begin
            hay[spot+i] = cur_needle[i];
            // swap the case of letters now and then when folding
            lowered = cur_needle[i] | LowerBit;
            if (cur_fold && lowered >= LowerA && lowered <= LowerZ
                && $urandom_range(0, 1) == 1) begin
               hay[spot+i] = cur_needle[i] ^ LowerBit;
            end
         end
      end
      for (i = 0; i < hay_len; i++) begin
         send_byte(hay[i], i == hay_len - 1);
      end
   endtask

   initial begin
      int k;
      req_bus.valid           = 1'b0;
      req_bus.data_byte       = '0;
      req_bus.end_of_haystack = 1'b0;
      csr_write_en            = 1'b0;
      csr_index               = REG_NEEDLE_LOW;
      csr_data                = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty needle in exact mode hits at offset 0 on the first byte
      program_needle('0, '0, 0, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      settle();

      // empty needle in case-fold mode never hits
      program_needle('1, '1, 0, 1'b1);
      send_byte(8'h41, 1'b0);
      send_byte(8'h61, 1'b1);
      settle();

      // case-fold edges: only A to Z fold, so '`' and '{' do not match '@' and '['
      program_needle(64'h7A5B40, '0, 3, 1'b1);
      send_byte(8'h60, 1'b0);
      send_byte(8'h7B, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h40, 1'b0);
      send_byte(8'h5B, 1'b0);
      send_byte(8'h5A, 1'b1);
      settle();

      // oversized length saturates to a full needle, zero bytes are plain data
      program_needle(64'h0706050403020100, 64'hFF0E0D0C0B0A0908, 31, 1'b0);
      for (k = 0; k < MaxNeedle; k++) begin
         send_byte((k == MaxNeedle - 1) ? 8'hFF : byte_type'(k), k == MaxNeedle - 1);
      end
      settle();

      // back-pressure: every byte is a one-byte haystack with a result
      program_needle({$urandom, $urandom}, {$urandom, $urandom}, 0, 1'b0);
      pressure_go = 1'b1;
      repeat (40) send_byte(random_byte(1'b0), 1'b1);
      settle();

      // random needles and haystacks
      while (items_sent < ItemTarget) begin
         quiet       = (items_sent >= ItemTarget - QuietItems);
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         random_config();
         repeat ($urandom_range(4, 12)) send_haystack();
         // sometimes leave a haystack open across the next register update
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 6)) send_byte(random_byte(1'b1), 1'b0);
         end
         settle();
      end

      if (error_count == 0) begin
         $display("streaming_substring_search_top_tb: done, clean");
      end else begin
         $display("streaming_substring_search_top_tb: done, errors");
      end
      $finish;
   end

endmodule
